/* sv/adcavg_pkg.sv */
// Shared types and constants for the multichannel ADC averager.
// No dependencies; compiled first.

package adcavg_pkg;

   // Fixed field widths of the request and response transactions
   localparam int SAMPLE_W      = 12;
   localparam int MUX_W         = 5;
   localparam int CHAN_W        = 3;
   localparam int AVG_W         = 12;
   localparam int MUX_TABLE_LEN = 8;

   // Analog mux code per scan position (position modulo table length)
   localparam logic [MUX_W-1:0] MUX_TABLE [MUX_TABLE_LEN] = '{
      5'd0, 5'd1, 5'd4, 5'd5, 5'd6, 5'd7, 5'd16, 5'd17
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [MUX_W-1:0] mux_code_for(input logic [2:0] pos);
      return MUX_TABLE[pos];
   endfunction

endpackage

/* sv/adcavg_if.sv */
// Valid/ready channel interfaces for request and response transactions.
// Depends on adcavg_pkg.

interface adcavg_req_if;
   import adcavg_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface adcavg_rsp_if;
   import adcavg_pkg::*;

   logic              valid;
   logic              ready;
   logic [MUX_W-1:0]  mux_code;
   logic              avg_valid;
   logic [CHAN_W-1:0] avg_channel;
   logic [AVG_W-1:0]  average;
   logic              last;

   modport source (output valid, output mux_code, output avg_valid, output avg_channel,
                   output average, output last, input ready);
   modport sink   (input valid, input mux_code, input avg_valid, input avg_channel,
                   input average, input last, output ready);
endinterface

/* sv/multichannel_adc_averager.sv */
// Latency: a transaction that does not end a scan gives its response the cycle after accept.
// A scan-ending transaction gives CHANNELS responses, one per channel; the time they take is
// set by the single history read port, which reads the filled slots one by one, and the shared
// bit-serial divider. Throughput: one transaction per cycle mid-scan while the response
// register can take a response; none accepted while averages are computed.
// Reset: synchronous, active high; scan position, slot and state clear, warm-up set.

module multichannel_adc_averager #(
   parameter int CHANNELS      = 8,
   parameter int HISTORY_DEPTH = 16,
   parameter int SAMPLE_BITS   = 12
) (
   input  logic                clock,
   input  logic                reset,
   adcavg_req_if.sink          req_bus,
   adcavg_rsp_if.source        rsp_bus
);
   import adcavg_pkg::*;

   localparam int CH_W       = $clog2(CHANNELS);
   localparam int SLOT_W     = $clog2(HISTORY_DEPTH);
   localparam int N_W        = $clog2(HISTORY_DEPTH + 1);
   localparam int STORE_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int SUM_W      = STORE_BITS + N_W;
   localparam int ADDR_W     = CH_W + SLOT_W;
   localparam int MEM_DEPTH  = 1 << ADDR_W;

   // Control state
   state_type         state_ff, state_in;
   logic [CH_W-1:0]   pos_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              warm_ff;
   logic [N_W-1:0]    n_ff;
   logic [N_W-1:0]    k_ff;
   logic [CH_W-1:0]   ch_ff;
   logic              rd_pend_ff;
   logic              rsp_valid_ff;

   // Datapath
   logic [MUX_W-1:0]      mux_ff;
   logic [SUM_W-1:0]      acc_ff;
   logic [STORE_BITS-1:0] rd_data_ff;
   logic [STORE_BITS-1:0] history_mem [MEM_DEPTH];

   // Response holding register
   logic [MUX_W-1:0]  rsp_mux_ff;
   logic              rsp_avg_valid_ff;
   logic [CHAN_W-1:0] rsp_chan_ff;
   logic [AVG_W-1:0]  rsp_avg_ff;
   logic              rsp_last_ff;

   // Combinational
   logic              req_fire;
   logic              rsp_free;
   logic              pos_wrap;
   logic              slot_wrap;
   logic [CH_W-1:0]   pos_next;
   logic [SLOT_W-1:0] slot_next;
   logic              warm_next;
   logic [N_W-1:0]    n_next;
   logic [CH_W+2:0]   pos_next_ext;
   logic [CH_W+2:0]   ch_ext;
   logic [MUX_W-1:0]  mux_next;
   logic              issue_done;
   logic              ch_last;
   logic [SUM_W+AVG_W-1:0] avg_ext;
   logic [AVG_W-1:0]  avg_val;
   logic [SUM_W-1:0]  quotient;
   div_stat_type      div_stat;

   // FSM outputs
   logic req_ready;
   logic rd_issue;
   logic div_start;
   logic avg_load;
   logic idle_load;
   logic rsp_load;

   assign req_fire = req_bus.valid && req_bus.ready;
   // Holding register can take a new response if empty or being drained this cycle
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // Scan position / history slot advance
   assign pos_wrap  = pos_ff == CH_W'(CHANNELS - 1);
   assign slot_wrap = slot_ff == SLOT_W'(HISTORY_DEPTH - 1);
   assign pos_next  = pos_wrap ? '0 : pos_ff + 1'b1;
   assign slot_next = pos_wrap ? (slot_wrap ? '0 : slot_ff + 1'b1) : slot_ff;
   assign warm_next = warm_ff && !(pos_wrap && slot_wrap);
   // Number of slots averaged: filled count in warm-up, full depth after first wrap
   assign n_next    = warm_next ? N_W'(slot_next) : N_W'(HISTORY_DEPTH);

   assign pos_next_ext = {3'b000, pos_next};
   assign mux_next     = mux_code_for(pos_next_ext[2:0]);
   assign ch_ext       = {3'b000, ch_ff};

   assign issue_done = k_ff == n_ff;
   assign ch_last    = ch_ff == CH_W'(CHANNELS - 1);
   assign avg_ext    = {{AVG_W{1'b0}}, quotient};
   assign avg_val    = (n_ff == '0) ? '0 : avg_ext[AVG_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && pos_wrap) state_in = ST_SUM;
         end
         ST_SUM: begin
            if (issue_done && !rd_pend_ff) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) state_in = ch_last ? ST_IDLE : ST_SUM;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // FSM outputs; no request is taken while reset is held
   always_comb begin
      req_ready = 1'b0;
      rd_issue  = 1'b0;
      div_start = 1'b0;
      avg_load  = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = rsp_free && !reset;
         ST_SUM: begin
            rd_issue  = !issue_done;
            div_start = issue_done && !rd_pend_ff;
         end
         ST_DIV: ;
         ST_OUT: avg_load = rsp_free;
         default: ;
      endcase
   end

   assign idle_load     = req_fire && !pos_wrap;
   assign rsp_load      = avg_load || idle_load;
   assign req_bus.ready = req_ready;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         slot_ff      <= '0;
         warm_ff      <= 1'b1;
         n_ff         <= '0;
         k_ff         <= '0;
         ch_ff        <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_issue;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire) begin
            pos_ff  <= pos_next;
            slot_ff <= slot_next;
            warm_ff <= warm_next;
            n_ff    <= n_next;
            k_ff    <= '0;
            ch_ff   <= '0;
         end else if (rd_issue) begin
            k_ff <= k_ff + 1'b1;
         end else if (avg_load && !ch_last) begin
            k_ff  <= '0;
            ch_ff <= ch_ff + 1'b1;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mux_ff <= mux_next;
         acc_ff <= '0;
      end else if (rd_pend_ff) begin
         acc_ff <= acc_ff + SUM_W'(rd_data_ff);
      end else if (avg_load) begin
         acc_ff <= '0;
      end
   end

   // History memory: one write port at accept, one registered read port
   always_ff @(posedge clock) begin
      if (req_fire) begin
         history_mem[{pos_ff, slot_ff}] <= req_bus.sample[STORE_BITS-1:0];
      end
      if (rd_issue) begin
         rd_data_ff <= history_mem[{ch_ff, k_ff[SLOT_W-1:0]}];
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (avg_load) begin
         rsp_mux_ff       <= mux_ff;
         rsp_avg_valid_ff <= 1'b1;
         rsp_chan_ff      <= ch_ext[CHAN_W-1:0];
         rsp_avg_ff       <= avg_val;
         rsp_last_ff      <= ch_last;
      end else if (idle_load) begin
         rsp_mux_ff       <= mux_next;
         rsp_avg_valid_ff <= 1'b0;
         rsp_chan_ff      <= '0;
         rsp_avg_ff       <= '0;
         rsp_last_ff      <= 1'b1;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.mux_code    = rsp_mux_ff;
   assign rsp_bus.avg_valid   = rsp_avg_valid_ff;
   assign rsp_bus.avg_channel = rsp_chan_ff;
   assign rsp_bus.average     = rsp_avg_ff;
   assign rsp_bus.last        = rsp_last_ff;

   // Shared divider: sum / slot count
   adcavg_divider #(
      .NUM_W (SUM_W),
      .DEN_W (N_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (n_ff),
      .quotient (quotient),
      .stat     (div_stat)
   );

   // Read index never runs past the slot count
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= n_ff)
      else $error("history read index past slot count");

   // Divider is never restarted mid-operation
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   // A pending response transaction is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("response register overwritten");

   // After warm-up, every average covers the full history
   a_full_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM && !warm_ff) |-> n_ff == N_W'(HISTORY_DEPTH))
      else $error("slot count wrong after warm-up");

   // Last average of a scan returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (avg_load && ch_last) |=> state_ff == ST_IDLE)
      else $error("sequencer did not return to idle after scan");

endmodule

/* sv/adcavg_divider.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on adcavg_pkg (status struct).

module adcavg_divider #(
   parameter int NUM_W = 17,
   parameter int DEN_W = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [NUM_W-1:0]           dividend,
   input  logic [DEN_W-1:0]           divisor,
   output logic [NUM_W-1:0]           quotient,
   output adcavg_pkg::div_stat_type   stat
);
   import adcavg_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   diff;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for multichannel_adc_averager: directed rows, then random scans.
// Depends on adcavg_pkg and the adcavg_req_if / adcavg_rsp_if interfaces.

module tb_top;
   import adcavg_pkg::*;

   localparam int CHANNELS      = 8;
   localparam int HISTORY_DEPTH = 16;
   localparam int SAMPLE_BITS   = 12;

   localparam int DIRECTED_ROWS = 24;
   localparam int RANDOM_ITEMS  = 360;
   localparam int TAIL_ITEMS    = 40;    // no idling on either side for these
   localparam int HOLD_AT_ITEM  = 40;    // receiver stalls once after this many accepts
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 400;   // margin for a scan end's averages to finish
   localparam int CYCLE_LIMIT   = 300000;

   // One response transaction as seen on the rsp channel
   typedef struct packed {
      logic [MUX_W-1:0]  mux_code;
      logic              avg_valid;
      logic [CHAN_W-1:0] avg_channel;
      logic [AVG_W-1:0]  average;
      logic              last;
   } scan_rsp_type;

   // Directed row: sample plus the mux code read straight off the table
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [MUX_W-1:0]    mux_code;
   } directed_row_type;

   logic clock;
   logic reset;

   adcavg_req_if req_bus ();
   adcavg_rsp_if rsp_bus ();

   multichannel_adc_averager #(
      .CHANNELS      (CHANNELS),
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // ---------------------------------------------------------------------------------------
   // Predictor state: own copy of the history, scan position, slot and warm-up flag
   // ---------------------------------------------------------------------------------------
   logic [SAMPLE_W-1:0] history [CHANNELS][HISTORY_DEPTH];
   int                  scan_pos;
   int                  slot;
   bit                  warming;

   scan_rsp_type scan_rsp_q [$];   // expected responses, oldest first
   int           error_count;
   int           accepted_count;
   int           cycle_count;
   bit           tail_phase;       // final stretch: both sides run flat out

   // Store one sample and queue the responses it causes; returns how many were queued.
   function automatic int advance_scan(input logic [SAMPLE_W-1:0] sample);
      int           next_pos;
      int           fill;
      int           sum;
      bit           scan_done;
      scan_rsp_type r;
      history[scan_pos][slot] = sample & ((1 << SAMPLE_BITS) - 1);
      next_pos  = scan_pos + 1;
      scan_done = 0;
      if (next_pos >= CHANNELS) begin
         next_pos  = 0;
         scan_done = 1;
         slot      = slot + 1;
         if (slot >= HISTORY_DEPTH) begin
            // history wrapped: full-depth average from this scan on
            slot    = 0;
            warming = 0;
         end
      end
      scan_pos   = next_pos;
      r.mux_code = MUX_TABLE[next_pos % MUX_TABLE_LEN];
      if (!scan_done) begin
         r.avg_valid   = 0;
         r.avg_channel = '0;
         r.average     = '0;
         r.last        = 1;
         scan_rsp_q.push_back(r);
         return 1;
      end
      // warm-up divides by the filled slots; slot is already advanced, so fill >= 1
      fill = warming ? slot : HISTORY_DEPTH;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         sum = 0;
         for (int k = 0; k < fill; k++)
            sum += history[ch][k];
         r.avg_valid   = 1;
         r.avg_channel = ch[CHAN_W-1:0];
         r.average     = AVG_W'(sum / fill);
         r.last        = (ch == CHANNELS - 1);
         scan_rsp_q.push_back(r);
      end
      return CHANNELS;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Clock, reset, watchdog
   // ---------------------------------------------------------------------------------------
   initial clock = 0;
   always #5 clock = ~clock;

   initial begin
      reset = 1;
      repeat (5) @(negedge clock);
      reset <= 0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Response checker: every accepted rsp transaction against the oldest expectation
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      scan_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (scan_rsp_q.size() == 0) begin
            $error("unexpected response: mux_code %0d avg_valid %0d avg_channel %0d average %0d",
                   rsp_bus.mux_code, rsp_bus.avg_valid, rsp_bus.avg_channel, rsp_bus.average);
            error_count++;
         end else begin
            want = scan_rsp_q.pop_front();
            if (rsp_bus.mux_code !== want.mux_code) begin
               $error("mux_code: expected %0d, got %0d", want.mux_code, rsp_bus.mux_code);
               error_count++;
            end
            if (rsp_bus.avg_valid !== want.avg_valid) begin
               $error("avg_valid: expected %0d, got %0d", want.avg_valid, rsp_bus.avg_valid);
               error_count++;
            end
            if (rsp_bus.avg_channel !== want.avg_channel) begin
               $error("avg_channel: expected %0d, got %0d", want.avg_channel,
                      rsp_bus.avg_channel);
               error_count++;
            end
            if (rsp_bus.average !== want.average) begin
               $error("average: expected %0d, got %0d", want.average, rsp_bus.average);
               error_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_bus.last);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Receiver: random ready bursts, one long hold-off so the block backs up and stalls
   // its input, then ready held high through the tail.
   // ---------------------------------------------------------------------------------------
   initial begin
      bit held_off;
      held_off      = 0;
      rsp_bus.ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (tail_phase) begin
            rsp_bus.ready <= 1;
            @(negedge clock);
         end else if (!held_off && accepted_count >= HOLD_AT_ITEM) begin
            held_off = 1;
            rsp_bus.ready <= 0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------------------------

   // Offer one sample from the next falling edge until it is taken; then predict.
   // When typed, the mux code of every response it causes is the hand-entered value.
   task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input bit typed,
                              input logic [MUX_W-1:0] typed_mux);
      int n;
      @(negedge clock);
      req_bus.valid  <= 1;
      req_bus.sample <= sample;
      do @(posedge clock); while (!req_bus.ready);
      accepted_count++;
      n = advance_scan(sample);
      if (typed)
         for (int i = scan_rsp_q.size() - n; i < scan_rsp_q.size(); i++)
            scan_rsp_q[i].mux_code = typed_mux;
   endtask

   // Drop valid for a gap whose length is drawn at random.
   task automatic sender_gap();
      int gap;
      gap = $urandom_range(1, 18);
      @(negedge clock);
      req_bus.valid <= 0;
      repeat (gap - 1) @(negedge clock);
   endtask

   // Three warm-up scans: extremes and alternating bit patterns first, then all-ones and
   // all-zeros scans so truncation of the warm-up division shows. Mux codes are the table
   // entry at the next scan position.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{12'h000, 5'd1},  '{12'hFFF, 5'd4},  '{12'h800, 5'd5},  '{12'h7FF, 5'd6},
      '{12'hAAA, 5'd7},  '{12'h555, 5'd16}, '{12'h001, 5'd17}, '{12'hFFE, 5'd0},
      '{12'hFFF, 5'd1},  '{12'hFFF, 5'd4},  '{12'hFFF, 5'd5},  '{12'hFFF, 5'd6},
      '{12'hFFF, 5'd7},  '{12'hFFF, 5'd16}, '{12'hFFF, 5'd17}, '{12'hFFF, 5'd0},
      '{12'h000, 5'd1},  '{12'h000, 5'd4},  '{12'h000, 5'd5},  '{12'h000, 5'd6},
      '{12'h000, 5'd7},  '{12'h000, 5'd16}, '{12'h000, 5'd17}, '{12'h000, 5'd0}
   };

   initial begin
      logic [SAMPLE_W-1:0] sample;
      int                  pick;

      req_bus.valid  = 0;
      req_bus.sample = '0;
      scan_pos       = 0;
      slot           = 0;
      warming        = 1;
      error_count    = 0;
      accepted_count = 0;
      cycle_count    = 0;
      tail_phase     = 0;

      @(negedge clock);
      while (reset) @(negedge clock);

      // directed part, a gap now and then so scan ends also see a slow sender
      foreach (directed_rows[i]) begin
         send_sample(directed_rows[i].sample, 1, directed_rows[i].mux_code);
         if ($urandom_range(0, 3) == 0)
            sender_gap();
      end

      // random part: every item is part of a scan, so the history wraps after 16 scans and
      // the full-depth average runs for the rest; extremes come up often
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - TAIL_ITEMS)
            tail_phase = 1;
         pick = $urandom_range(0, 7);
         if (pick == 0)
            sample = '0;
         else if (pick == 1)
            sample = '1;
         else
            sample = SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
         send_sample(sample, 0, '0);
         if (!tail_phase && $urandom_range(0, 3) == 0)
            sender_gap();
      end

      @(negedge clock);
      req_bus.valid <= 0;

      // drain, then give a scan end's worth of cycles for any stray transaction
      while (scan_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && scan_rsp_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
